// File: rtl/thpsc_pkg.sv
// thpsc_pkg: shared types and constants for the sensor compensation block
// used by thp_sensor_compensation; depends on nothing else
`default_nettype none

package thpsc_pkg;

   // input and result word layout
   localparam int ADC_T_W   = 20;
   localparam int ADC_P_W   = 20;
   localparam int ADC_H_W   = 16;
   localparam int REQ_W     = 56;
   localparam int TEMP_W    = 15;
   localparam int PRES_W    = 25;
   localparam int HUM_W     = 17;
   localparam int RSP_W     = 64;

   // configuration port
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 64;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESA = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESB = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PRES9 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HUM   = 3'd4;

   // shared multiplier and datapath widths
   localparam int MA_W   = 40;
   localparam int MB_W   = 26;
   localparam int PR_W   = MA_W + MB_W;
   localparam int FINE_W = 24;
   localparam int NUM_W  = 74;
   localparam int DEN_W  = 40;
   localparam int QUO_W  = 37;
   localparam int CNT_W  = 6;

   localparam logic [ADC_T_W-1:0] SKIP_CODE = 20'h80000;
   localparam logic [11:0]        PQ_SCALE  = 12'd3125;

   // sequencer, one-hot
   localparam int ST_W = 48;
   typedef enum logic [ST_W-1:0] {
      ST_IDLE  = ST_W'(1) << 0,
      ST_T0    = ST_W'(1) << 1,
      ST_T1    = ST_W'(1) << 2,
      ST_T2    = ST_W'(1) << 3,
      ST_T3    = ST_W'(1) << 4,
      ST_T4    = ST_W'(1) << 5,
      ST_P0    = ST_W'(1) << 6,
      ST_P1    = ST_W'(1) << 7,
      ST_P2    = ST_W'(1) << 8,
      ST_P3    = ST_W'(1) << 9,
      ST_P4    = ST_W'(1) << 10,
      ST_P5    = ST_W'(1) << 11,
      ST_P6    = ST_W'(1) << 12,
      ST_P7    = ST_W'(1) << 13,
      ST_P8    = ST_W'(1) << 14,
      ST_P9    = ST_W'(1) << 15,
      ST_P10   = ST_W'(1) << 16,
      ST_P11   = ST_W'(1) << 17,
      ST_P12   = ST_W'(1) << 18,
      ST_P13   = ST_W'(1) << 19,
      ST_P14   = ST_W'(1) << 20,
      ST_P15   = ST_W'(1) << 21,
      ST_DINIT = ST_W'(1) << 22,
      ST_DLOOP = ST_W'(1) << 23,
      ST_DFIN  = ST_W'(1) << 24,
      ST_Q1    = ST_W'(1) << 25,
      ST_Q2    = ST_W'(1) << 26,
      ST_Q3    = ST_W'(1) << 27,
      ST_Q4    = ST_W'(1) << 28,
      ST_Q5    = ST_W'(1) << 29,
      ST_Q6    = ST_W'(1) << 30,
      ST_Q7    = ST_W'(1) << 31,
      ST_Q8    = ST_W'(1) << 32,
      ST_H0    = ST_W'(1) << 33,
      ST_H1    = ST_W'(1) << 34,
      ST_H2    = ST_W'(1) << 35,
      ST_H3    = ST_W'(1) << 36,
      ST_H4    = ST_W'(1) << 37,
      ST_H5    = ST_W'(1) << 38,
      ST_H6    = ST_W'(1) << 39,
      ST_H7    = ST_W'(1) << 40,
      ST_H8    = ST_W'(1) << 41,
      ST_H9    = ST_W'(1) << 42,
      ST_H10   = ST_W'(1) << 43,
      ST_H11   = ST_W'(1) << 44,
      ST_H12   = ST_W'(1) << 45,
      ST_H13   = ST_W'(1) << 46,
      ST_FIN   = ST_W'(1) << 47
   } state_type;

endpackage

`default_nettype wire

// File: rtl/thp_sensor_compensation.sv
// Compensates one raw temperature, pressure and humidity set per word using the calibration
// registers. One signed 40x26 multiplier and a one-bit-per-cycle restoring divider are shared
// by all terms under a one-hot sequencer. An accepted item runs through the temperature
// steps, the pressure steps (the divider loop among them) and the humidity steps and handoff;
// the sequencer then returns to idle before it takes the next word. A skipped temperature
// or pressure, a zero pressure divisor or a saturated pressure quotient shortens the run.
// req_tready is high only while the sequencer is idle; a finished result waits in the output
// register without holding off the next input word.
// Depends on thpsc_pkg.
`default_nettype none

module thp_sensor_compensation (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_tvalid,
   output logic                          req_tready,
   // adc_temperature [19:0], adc_pressure [39:20], adc_humidity [55:40]
   input  wire  [thpsc_pkg::REQ_W-1:0]   req_tdata,
   output logic                          rsp_tvalid,
   input  wire                           rsp_tready,
   // temperature_centi [14:0], pressure_q17_8 [39:15], humidity_q7_10 [56:40], zeros above
   output logic [thpsc_pkg::RSP_W-1:0]   rsp_tdata,
   input  wire                           csr_wr_en,
   input  wire  [thpsc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire  [thpsc_pkg::CSR_W-1:0]   csr_wdata
);
   import thpsc_pkg::*;

   // calibration registers
   logic [47:0] temp_cal_ff;
   logic [63:0] pres_a_ff;
   logic [63:0] pres_b_ff;
   logic [15:0] pres_9_ff;
   logic [63:0] hum_cal_ff;

   state_type state_ff, state_in;

   logic signed [FINE_W-1:0] fine_ff, fine_in;
   logic [ADC_T_W-1:0] adc_t_ff, adc_t_in;
   logic [ADC_P_W-1:0] adc_p_ff, adc_p_in;
   logic [ADC_H_W-1:0] adc_h_ff, adc_h_in;

   logic signed [MA_W-1:0] mul_a;
   logic signed [MB_W-1:0] mul_b;
   logic signed [PR_W-1:0] prod_ff, prod_in;

   logic signed [63:0] acc_ff, acc_in;
   logic signed [63:0] acc2_ff, acc2_in;
   logic [47:0] vv_ff, vv_in;
   logic signed [DEN_W-1:0] d_ff, d_in;
   logic signed [63:0] x_ff, x_in;
   logic [61:0] xa_ff, xa_in;
   logic [DEN_W-1:0] da_ff, da_in;
   logic neg_ff, neg_in;
   logic qsat_ff, qsat_in;
   logic [NUM_W-1:0] n_ff, n_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] nq_ff, nq_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic signed [QUO_W:0] p_ff, p_in;
   logic signed [23:0] ha_ff, ha_in;
   logic signed [23:0] w_ff, w_in;
   logic signed [23:0] w2_ff, w2_in;
   logic signed [DEN_W-1:0] bh_ff, bh_in;
   logic signed [31:0] hs_ff, hs_in;

   logic signed [TEMP_W-1:0] tres_ff, tres_in;
   logic [PRES_W-1:0] pres_ff, pres_in;
   logic [HUM_W-1:0]  hres_ff, hres_in;

   logic rsp_vld_ff, rsp_vld_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   // coefficient fields
   logic [15:0]        t1;
   logic signed [15:0] t2, t3;
   logic [15:0]        p1;
   logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
   logic [7:0]         h1, h3;
   logic signed [15:0] h2;
   logic signed [11:0] h4, h5;
   logic signed [7:0]  h6;

   // local arithmetic
   logic signed [18:0] ta;
   logic signed [17:0] tb;
   logic signed [24:0] pv, hv;
   logic signed [63:0] fsum;
   logic signed [27:0] f5;
   logic signed [27:0] tq;
   logic [20:0]        xm;
   logic [DEN_W-1:0]   rem2;
   logic [QUO_W-1:0]   qv;
   logic signed [63:0] psum;
   logic signed [63:0] hbase;
   logic signed [16:0] s17;

   assign t1 = temp_cal_ff[15:0];
   assign t2 = $signed(temp_cal_ff[31:16]);
   assign t3 = $signed(temp_cal_ff[47:32]);
   assign p1 = pres_a_ff[15:0];
   assign p2 = $signed(pres_a_ff[31:16]);
   assign p3 = $signed(pres_a_ff[47:32]);
   assign p4 = $signed(pres_a_ff[63:48]);
   assign p5 = $signed(pres_b_ff[15:0]);
   assign p6 = $signed(pres_b_ff[31:16]);
   assign p7 = $signed(pres_b_ff[47:32]);
   assign p8 = $signed(pres_b_ff[63:48]);
   assign p9 = $signed(pres_9_ff);
   assign h1 = hum_cal_ff[7:0];
   assign h2 = $signed(hum_cal_ff[23:8]);
   assign h3 = hum_cal_ff[31:24];
   assign h4 = $signed(hum_cal_ff[43:32]);
   assign h5 = $signed(hum_cal_ff[55:44]);
   assign h6 = $signed(hum_cal_ff[63:56]);

   assign ta = $signed({2'b00, adc_t_ff[19:3]}) - $signed({2'b00, t1, 1'b0});
   assign tb = $signed({2'b00, adc_t_ff[19:4]}) - $signed({2'b00, t1});
   assign pv = 25'(fine_ff) - 25'sd128000;
   assign hv = 25'(fine_ff) - 25'sd76800;
   assign xm = 21'h100000 - {1'b0, adc_p_ff};
   assign rem2 = {rem_ff[DEN_W-2:0], nq_ff[QUO_W-1]};
   assign s17 = 17'(hs_ff >>> 15);
   assign hbase = $signed(64'({adc_h_ff, 14'd0})) + 64'sd16384 - (64'(h4) <<< 20);

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   // shared multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_T0: begin
            mul_a = MA_W'(ta);
            mul_b = MB_W'(t2);
         end
         ST_T1: begin
            mul_a = MA_W'(tb);
            mul_b = MB_W'(tb);
         end
         ST_T2: begin
            mul_a = MA_W'(prod_ff >>> 12);
            mul_b = MB_W'(t3);
         end
         ST_P0: begin
            mul_a = MA_W'(pv);
            mul_b = MB_W'(pv);
         end
         ST_P1: begin
            mul_a = MA_W'(pv);
            mul_b = MB_W'(p5);
         end
         ST_P2: begin
            mul_a = MA_W'(pv);
            mul_b = MB_W'(p2);
         end
         ST_P3: begin
            mul_a = MA_W'(vv_ff[47:24]);
            mul_b = MB_W'(p6);
         end
         ST_P4: begin
            mul_a = MA_W'(vv_ff[23:0]);
            mul_b = MB_W'(p6);
         end
         ST_P5: begin
            mul_a = MA_W'(vv_ff[47:24]);
            mul_b = MB_W'(p3);
         end
         ST_P6: begin
            mul_a = MA_W'(vv_ff[23:0]);
            mul_b = MB_W'(p3);
         end
         ST_P8: begin
            mul_a = MA_W'(acc2_ff >>> 33);
            mul_b = MB_W'(p1);
         end
         ST_P9: begin
            mul_a = MA_W'(acc2_ff[32:0]);
            mul_b = MB_W'(p1);
         end
         ST_P13: begin
            mul_a = MA_W'(xa_ff[61:31]);
            mul_b = MB_W'(PQ_SCALE);
         end
         ST_P14: begin
            mul_a = MA_W'(xa_ff[30:0]);
            mul_b = MB_W'(PQ_SCALE);
         end
         ST_Q1: begin
            mul_a = MA_W'(p_ff >>> 13);
            mul_b = MB_W'(p_ff >>> 13);
         end
         ST_Q2: begin
            mul_a = MA_W'(p_ff);
            mul_b = MB_W'(p8);
         end
         ST_Q3: begin
            mul_a = MA_W'(vv_ff[47:24]);
            mul_b = MB_W'(p9);
         end
         ST_Q4: begin
            mul_a = MA_W'(vv_ff[23:0]);
            mul_b = MB_W'(p9);
         end
         ST_H0: begin
            mul_a = MA_W'(hv);
            mul_b = MB_W'(h5);
         end
         ST_H1: begin
            mul_a = MA_W'(hv);
            mul_b = MB_W'(h6);
         end
         ST_H2: begin
            mul_a = MA_W'(hv);
            mul_b = MB_W'(h3);
         end
         ST_H4: begin
            mul_a = MA_W'(w_ff);
            mul_b = MB_W'(w2_ff);
         end
         ST_H6: begin
            mul_a = MA_W'(bh_ff);
            mul_b = MB_W'(h2);
         end
         ST_H8: begin
            mul_a = MA_W'(bh_ff);
            mul_b = MB_W'(ha_ff);
         end
         ST_H10: begin
            mul_a = MA_W'(s17);
            mul_b = MB_W'(s17);
         end
         ST_H11: begin
            mul_a = MA_W'(prod_ff >>> 7);
            mul_b = MB_W'(h1);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // sequencer and datapath updates
   always_comb begin
      state_in = state_ff;
      fine_in  = fine_ff;
      adc_t_in = adc_t_ff;
      adc_p_in = adc_p_ff;
      adc_h_in = adc_h_ff;
      acc_in   = acc_ff;
      acc2_in  = acc2_ff;
      vv_in    = vv_ff;
      d_in     = d_ff;
      x_in     = x_ff;
      xa_in    = xa_ff;
      da_in    = da_ff;
      neg_in   = neg_ff;
      qsat_in  = qsat_ff;
      n_in     = n_ff;
      rem_in   = rem_ff;
      nq_in    = nq_ff;
      cnt_in   = cnt_ff;
      p_in     = p_ff;
      ha_in    = ha_ff;
      w_in     = w_ff;
      w2_in    = w2_ff;
      bh_in    = bh_ff;
      hs_in    = hs_ff;
      tres_in  = tres_ff;
      pres_in  = pres_ff;
      hres_in  = hres_ff;
      rsp_vld_in  = rsp_vld_ff & ~rsp_tready;
      rsp_data_in = rsp_data_ff;
      fsum = acc_ff + 64'(prod_ff >>> 14);
      f5   = (28'(fine_ff) <<< 2) + 28'(fine_ff) + 28'sd128;
      tq   = f5 >>> 8;
      qv   = '0;
      psum = (acc_ff >>> 8) + (64'(p7) <<< 4);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               adc_t_in = req_tdata[19:0];
               adc_p_in = req_tdata[39:20];
               adc_h_in = req_tdata[55:40];
               tres_in  = '0;
               pres_in  = '0;
               if (req_tdata[19:0] != SKIP_CODE) begin
                  state_in = ST_T0;
               end else if (req_tdata[39:20] != SKIP_CODE) begin
                  state_in = ST_P0;
               end else begin
                  state_in = ST_H0;
               end
            end
         end
         ST_T0: state_in = ST_T1;
         ST_T1: begin
            acc_in   = 64'(prod_ff >>> 11);
            state_in = ST_T2;
         end
         ST_T2: state_in = ST_T3;
         ST_T3: begin
            if (fsum < -64'sd8388608) begin
               fine_in = 24'sh80_0000;
            end else if (fsum > 64'sd8388607) begin
               fine_in = 24'sd8388607;
            end else begin
               fine_in = 24'(fsum);
            end
            state_in = ST_T4;
         end
         ST_T4: begin
            if (tq < -28'sd4000) begin
               tres_in = -15'sd4000;
            end else if (tq > 28'sd8500) begin
               tres_in = 15'sd8500;
            end else begin
               tres_in = 15'(tq);
            end
            state_in = (adc_p_ff != SKIP_CODE) ? ST_P0 : ST_H0;
         end
         ST_P0: state_in = ST_P1;
         ST_P1: begin
            vv_in    = 48'(prod_ff);
            state_in = ST_P2;
         end
         ST_P2: begin
            acc_in   = (64'(prod_ff) <<< 17) + (64'(p4) <<< 35);
            state_in = ST_P3;
         end
         ST_P3: begin
            // offset of 2^47 folded in here
            acc2_in  = (64'(prod_ff) <<< 12) + 64'sh0000_8000_0000_0000;
            state_in = ST_P4;
         end
         ST_P4: begin
            acc_in   = acc_ff + (64'(prod_ff) <<< 24);
            state_in = ST_P5;
         end
         ST_P5: begin
            acc_in   = acc_ff + 64'(prod_ff);
            state_in = ST_P6;
         end
         ST_P6: begin
            // high half is a multiple of 256, so the shift splits over the halves
            acc2_in  = acc2_ff + (64'(prod_ff) <<< 16);
            state_in = ST_P7;
         end
         ST_P7: begin
            acc2_in  = acc2_ff + 64'(prod_ff >>> 8);
            state_in = ST_P8;
         end
         ST_P8: state_in = ST_P9;
         ST_P9: begin
            d_in     = DEN_W'(prod_ff);
            state_in = ST_P10;
         end
         ST_P10: begin
            d_in     = d_ff + DEN_W'(prod_ff >>> 33);
            state_in = ST_P11;
         end
         ST_P11: begin
            x_in = $signed(64'(xm) << 31) - acc_ff;
            if (d_ff == '0) begin
               pres_in  = '0;
               state_in = ST_H0;
            end else begin
               state_in = ST_P12;
            end
         end
         ST_P12: begin
            xa_in    = 62'(x_ff[63] ? -x_ff : x_ff);
            da_in    = DEN_W'(d_ff[DEN_W-1] ? -d_ff : d_ff);
            neg_in   = x_ff[63] ^ d_ff[DEN_W-1];
            state_in = ST_P13;
         end
         ST_P13: state_in = ST_P14;
         ST_P14: begin
            n_in     = {31'd0, prod_ff[42:0]} << 31;
            state_in = ST_P15;
         end
         ST_P15: begin
            n_in     = n_ff + {31'd0, prod_ff[42:0]};
            state_in = ST_DINIT;
         end
         ST_DINIT: begin
            // quotient of 2^37 or more saturates without iterating
            if (DEN_W'(n_ff[NUM_W-1:QUO_W]) >= da_ff) begin
               qsat_in  = 1'b1;
               state_in = ST_DFIN;
            end else begin
               qsat_in  = 1'b0;
               rem_in   = DEN_W'(n_ff[NUM_W-1:QUO_W]);
               nq_in    = n_ff[QUO_W-1:0];
               cnt_in   = CNT_W'(QUO_W - 1);
               state_in = ST_DLOOP;
            end
         end
         ST_DLOOP: begin
            if (rem2 >= da_ff) begin
               rem_in = rem2 - da_ff;
               nq_in  = {nq_ff[QUO_W-2:0], 1'b1};
            end else begin
               rem_in = rem2;
               nq_in  = {nq_ff[QUO_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_DFIN;
            end
         end
         ST_DFIN: begin
            if (qsat_ff || (nq_ff > 37'h10_0000_0000)) begin
               qv = 37'h10_0000_0000;
            end else begin
               qv = nq_ff;
            end
            p_in     = neg_ff ? -$signed({1'b0, qv}) : $signed({1'b0, qv});
            state_in = ST_Q1;
         end
         ST_Q1: state_in = ST_Q2;
         ST_Q2: begin
            vv_in    = 48'(prod_ff);
            state_in = ST_Q3;
         end
         ST_Q3: begin
            acc_in   = 64'(prod_ff >>> 19);
            state_in = ST_Q4;
         end
         ST_Q4: begin
            acc2_in  = 64'(prod_ff) <<< 24;
            state_in = ST_Q5;
         end
         ST_Q5: begin
            acc2_in  = acc2_ff + 64'(prod_ff);
            state_in = ST_Q6;
         end
         ST_Q6: begin
            acc_in   = acc_ff + (acc2_ff >>> 25);
            state_in = ST_Q7;
         end
         ST_Q7: begin
            acc_in   = acc_ff + 64'(p_ff);
            state_in = ST_Q8;
         end
         ST_Q8: begin
            if (psum < 64'sd0) begin
               pres_in = '0;
            end else if (psum > 64'sd33554431) begin
               pres_in = '1;
            end else begin
               pres_in = PRES_W'(psum);
            end
            state_in = ST_H0;
         end
         ST_H0: state_in = ST_H1;
         ST_H1: begin
            acc_in   = hbase - 64'(prod_ff);
            state_in = ST_H2;
         end
         ST_H2: begin
            ha_in    = 24'(acc_ff >>> 15);
            w_in     = 24'(prod_ff >>> 10);
            state_in = ST_H3;
         end
         ST_H3: begin
            w2_in    = 24'(prod_ff >>> 11) + 24'sd32768;
            state_in = ST_H4;
         end
         ST_H4: state_in = ST_H5;
         ST_H5: begin
            bh_in    = DEN_W'(prod_ff >>> 10) + 40'sd2097152;
            state_in = ST_H6;
         end
         ST_H6: state_in = ST_H7;
         ST_H7: begin
            bh_in    = DEN_W'((prod_ff + 66'sd8192) >>> 14);
            state_in = ST_H8;
         end
         ST_H8: state_in = ST_H9;
         ST_H9: begin
            if (prod_ff > 66'sd2147483647) begin
               hs_in = 32'sh7fff_ffff;
            end else if (prod_ff < -66'sd2147483648) begin
               hs_in = 32'sh8000_0000;
            end else begin
               hs_in = 32'(prod_ff);
            end
            state_in = ST_H10;
         end
         ST_H10: state_in = ST_H11;
         ST_H11: state_in = ST_H12;
         ST_H12: begin
            acc_in   = 64'(hs_ff) - 64'(prod_ff >>> 4);
            state_in = ST_H13;
         end
         ST_H13: begin
            if (acc_ff < 64'sd0) begin
               hres_in = '0;
            end else if (acc_ff > 64'sd419430400) begin
               hres_in = 17'd102400;
            end else begin
               hres_in = HUM_W'(acc_ff >>> 12);
            end
            state_in = ST_FIN;
         end
         ST_FIN: begin
            // hand off once the output register is free
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = {7'd0, hres_ff, pres_ff, tres_ff};
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         fine_ff     <= '0;
         rsp_vld_ff  <= 1'b0;
         temp_cal_ff <= '0;
         pres_a_ff   <= '0;
         pres_b_ff   <= '0;
         pres_9_ff   <= '0;
         hum_cal_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         fine_ff    <= fine_in;
         rsp_vld_ff <= rsp_vld_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_TEMP:  temp_cal_ff <= csr_wdata[47:0];
               CSR_PRESA: pres_a_ff   <= csr_wdata;
               CSR_PRESB: pres_b_ff   <= csr_wdata;
               CSR_PRES9: pres_9_ff   <= csr_wdata[15:0];
               CSR_HUM:   hum_cal_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      adc_t_ff    <= adc_t_in;
      adc_p_ff    <= adc_p_in;
      adc_h_ff    <= adc_h_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      acc2_ff     <= acc2_in;
      vv_ff       <= vv_in;
      d_ff        <= d_in;
      x_ff        <= x_in;
      xa_ff       <= xa_in;
      da_ff       <= da_in;
      neg_ff      <= neg_in;
      qsat_ff     <= qsat_in;
      n_ff        <= n_in;
      rem_ff      <= rem_in;
      nq_ff       <= nq_in;
      cnt_ff      <= cnt_in;
      p_ff        <= p_in;
      ha_ff       <= ha_in;
      w_ff        <= w_in;
      w2_ff       <= w2_in;
      bh_ff       <= bh_in;
      hs_ff       <= hs_in;
      tres_ff     <= tres_in;
      pres_ff     <= pres_in;
      hres_ff     <= hres_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire
